// File: rtl/sla_pkg.sv
`default_nettype none
package sla_pkg;

    localparam int LEN_W = 7;
    localparam int CNT_W = 16;

    localparam logic [7:0]       NEWLINE   = 8'h0A;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_RX_ERROR = 2'd1,
        OP_POP      = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACCEPT  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_POPPED  = 2'd2,
        KIND_EMPTY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA
    } t_state;

endpackage
`default_nettype wire

// File: rtl/sla_ram.sv
`default_nettype none
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/serial_line_assembler_fifo.sv
`default_nettype none
// Serial line assembler with a queue of whole lines.
// Input: drive i_operation and i_rx_byte with i_start; the word is taken at a
// clock edge where i_start is high and o_busy is low.
// Received bytes are written straight into the free slot after the newest
// line; a newline or a full line closes it. A closing byte gives one result
// (accepted or dropped) in the next cycle; other bytes and receive errors give
// none. Bytes and errors keep o_busy low.
// A pop of an empty queue answers in the next cycle with a single empty result.
// A pop of a held line raises o_busy, reads the length memory in state ST_LEN,
// then streams the line one byte per cycle in state ST_DATA; o_busy falls
// again after the last byte. The rate is set by the single read port of the
// line byte memory.
// Each result sits on the outputs for one cycle with o_valid high; the
// receiver cannot stall the block.
// Reset (synchronous, i_rst_n low) empties the queue, clears the partial line
// and both error counters; the memories are not cleared.
module serial_line_assembler_fifo
    import sla_pkg::*;
#(
    parameter int MAX_LINE    = 64,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic [1:0]       i_operation,
    input  wire logic [7:0]       i_rx_byte,
    output logic                  o_valid,
    output logic      [1:0]       o_kind,
    output logic      [7:0]       o_data_byte,
    output logic      [LEN_W-1:0] o_line_length,
    output logic                  o_is_last,
    output logic      [CNT_W-1:0] o_queue_full_errors,
    output logic      [CNT_W-1:0] o_overrun_errors,
    output logic      [LEN_W-1:0] o_lines_queued
);

    localparam int SLOTS = QUEUE_DEPTH + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(MAX_LINE);
    localparam int FW    = $clog2(MAX_LINE + 1);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = SW + LW;

    t_state           r_state, n_state;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_tail, n_tail;
    logic [SW-1:0]    r_pop_slot, n_pop_slot;
    logic [CW-1:0]    r_count, n_count;
    logic [FW-1:0]    r_fill, n_fill;
    logic [FW-1:0]    r_len, n_len;
    logic [LW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_full_err, n_full_err;
    logic [CNT_W-1:0] r_overrun, n_overrun;
    logic             r_res_valid, n_res_valid;
    t_kind            r_res_kind, n_res_kind;
    logic [FW-1:0]    r_res_len, n_res_len;

    logic          accept;
    t_op           op;
    logic [FW-1:0] fill_inc;
    logic          line_close;
    logic          byte_last;
    logic          byte_we;
    logic [AW-1:0] byte_raddr;
    logic [7:0]    byte_rdata;
    logic          len_we;
    logic [FW-1:0] len_rdata;

    function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
        return (s == SW'(QUEUE_DEPTH)) ? '0 : s + 1'b1;
    endfunction

    assign accept     = i_start && (r_state == ST_IDLE);
    assign op         = t_op'(i_operation);
    assign fill_inc   = r_fill + 1'b1;
    assign line_close = (i_rx_byte == NEWLINE) || (fill_inc == FW'(MAX_LINE));
    assign byte_last  = (FW'(r_idx) + 1'b1) == r_len;
    assign byte_we    = accept && (op == OP_RX_BYTE);
    assign len_we     = byte_we && line_close && (r_count < CW'(QUEUE_DEPTH));
    assign byte_raddr = (r_state == ST_DATA) ? {r_pop_slot, r_idx + 1'b1}
                                             : {r_pop_slot, {LW{1'b0}}};

    sla_ram #(
        .WIDTH(8),
        .DEPTH(SLOTS << LW)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr ({r_tail, r_fill[LW-1:0]}),
        .i_wdata (i_rx_byte),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    sla_ram #(
        .WIDTH(FW),
        .DEPTH(SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_tail),
        .i_wdata (fill_inc),
        .i_raddr (r_head),
        .o_rdata (len_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (op == OP_POP) && (r_count != '0)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_state = ST_DATA;
            end
            ST_DATA: begin
                if (byte_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_pop_slot  = r_pop_slot;
        n_count     = r_count;
        n_fill      = r_fill;
        n_len       = r_len;
        n_idx       = r_idx;
        n_full_err  = r_full_err;
        n_overrun   = r_overrun;
        n_res_valid = 1'b0;
        n_res_kind  = r_res_kind;
        n_res_len   = r_res_len;
        if (r_state == ST_LEN) begin
            n_len = len_rdata;
            n_idx = '0;
        end
        if (r_state == ST_DATA) begin
            n_idx = r_idx + 1'b1;
        end
        if (accept) begin
            case (op)
                OP_RX_BYTE: begin
                    n_fill = fill_inc;
                    if (line_close) begin
                        n_fill      = '0;
                        n_res_valid = 1'b1;
                        n_res_len   = fill_inc;
                        if (r_count < CW'(QUEUE_DEPTH)) begin
                            n_res_kind = KIND_ACCEPT;
                            n_tail     = slot_next(r_tail);
                            n_count    = r_count + 1'b1;
                        end else begin
                            n_res_kind = KIND_DROPPED;
                            if (r_full_err != COUNT_MAX) begin
                                n_full_err = r_full_err + 1'b1;
                            end
                        end
                    end
                end
                OP_RX_ERROR: begin
                    n_fill = '0;
                    if (r_overrun != COUNT_MAX) begin
                        n_overrun = r_overrun + 1'b1;
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_res_valid = 1'b1;
                        n_res_kind  = KIND_EMPTY;
                        n_res_len   = '0;
                    end else begin
                        n_pop_slot = r_head;
                        n_head     = slot_next(r_head);
                        n_count    = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_busy              = (r_state != ST_IDLE);
        o_queue_full_errors = r_full_err;
        o_overrun_errors    = r_overrun;
        o_lines_queued      = LEN_W'(r_count);
        if (r_state == ST_DATA) begin
            o_valid       = 1'b1;
            o_kind        = KIND_POPPED;
            o_data_byte   = byte_rdata;
            o_line_length = LEN_W'(r_len);
            o_is_last     = byte_last;
        end else begin
            o_valid       = r_res_valid;
            o_kind        = r_res_kind;
            o_data_byte   = '0;
            o_line_length = LEN_W'(r_res_len);
            o_is_last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_full_err  <= '0;
            r_overrun   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_full_err  <= n_full_err;
            r_overrun   <= n_overrun;
            r_res_valid <= n_res_valid;
        end
        r_pop_slot <= n_pop_slot;
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_res_kind <= n_res_kind;
        r_res_len  <= n_res_len;
    end

endmodule
`default_nettype wire
